// ----- hdl/heq_pkg.sv -----
// Shared constants and types for the histogram equalizer core.
// Depends on nothing; imported by the core and by its port checker.
`default_nettype none
package heq_pkg;

  localparam int FRAME_PIXELS = 4096;
  localparam int PIX_W        = 8;
  localparam int LEVELS       = 2 ** PIX_W;
  localparam int OP_W         = 2;
  localparam int SHIFT_W      = 3;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 3;

  // A bin and the cumulative sum both saturate at the frame size.
  localparam int BIN_W        = $clog2(FRAME_PIXELS + 1);
  localparam int HALF_FRAME   = FRAME_PIXELS / 2;

  // Numerator of the table formula: 255*cum + N/2, with cum <= N.
  localparam int NUM_MAX      = 255 * FRAME_PIXELS + HALF_FRAME;
  localparam int NUM_W        = $clog2(NUM_MAX + 1);

  // Reciprocal of N scaled by 2^NUM_W: the estimate is low by at most one.
  localparam int RECIP_SHIFT  = NUM_W;
  localparam int RECIP        = (2 ** RECIP_SHIFT) / FRAME_PIXELS;
  localparam int RECIP_W      = $clog2(RECIP + 1);
  localparam int PROD_W       = NUM_W + RECIP_W;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_COUNT = 2'd1,
    OP_BUILD = 2'd2,
    OP_MAP   = 2'd3
  } opcode_t;

  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_SHIFT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EQUALIZE_ENABLE = 1'd1;

endpackage
`default_nettype wire

// ----- hdl/histogram_equalizer_core.sv -----
// Top level of the 8-bit histogram equalizer: bin memory, table memory,
// count and build pipelines. Depends on heq_pkg.
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_ready    in_opcode, in_pixel
//   out_     output     out_valid / out_ready  out_mapped_pixel
//   cfg_     input      cfg_we (no wait)       cfg_index, cfg_wdata
//
// Count and map items are taken one per cycle while no build runs, map items
// only while the output has room. A build item walks the 256 bins through a
// six-stage pipeline (bin read, accumulate, numerator, reciprocal multiply,
// quotient, correct and write); the input stays closed until the pipe drains.
// Reset clears the per-bin valid flags at once, so there is no clearing pass.
// A stalled result holds in the output register; only map items wait for it,
// other items keep flowing.
`default_nettype none
module histogram_equalizer_core (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [heq_pkg::OP_W-1:0]     in_opcode,
  input  wire  [heq_pkg::PIX_W-1:0]    in_pixel,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [heq_pkg::PIX_W-1:0]    out_mapped_pixel,
  input  wire                          cfg_we,
  input  wire  [heq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [heq_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import heq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  state_t state_r, state_nxt;
  logic [PIX_W-1:0] idx_r, idx_nxt;

  // Configuration registers.
  logic [SHIFT_W-1:0] shift_r;
  logic               enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r  <= SHIFT_W'(3);
      enable_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OUTPUT_SHIFT:    shift_r  <= cfg_wdata[SHIFT_W-1:0];
        REG_EQUALIZE_ENABLE: enable_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Input handshake. Map items need room in the output register; every
  // other opcode goes in whenever no build is running.
  logic in_acc, clr_acc, cnt_acc, bld_acc, map_acc;
  logic out_room;

  assign out_room = !out_valid || out_ready;
  assign in_ready = (state_r == ST_IDLE) &&
                    ((opcode_t'(in_opcode) != OP_MAP) || out_room);
  assign in_acc   = in_valid && in_ready;
  assign clr_acc  = in_acc && (opcode_t'(in_opcode) == OP_CLEAR);
  assign cnt_acc  = in_acc && (opcode_t'(in_opcode) == OP_COUNT);
  assign bld_acc  = in_acc && (opcode_t'(in_opcode) == OP_BUILD);
  assign map_acc  = in_acc && (opcode_t'(in_opcode) == OP_MAP);

  // Bin memory. One read port shared by counting and the build scan, one
  // write port used by counting. Each bin has a valid flag; a bin whose
  // flag is low reads as zero, which is how clear and reset empty it.
  logic [BIN_W-1:0] bin_mem [LEVELS];
  logic             bin_vld_r [LEVELS];
  logic [BIN_W-1:0] bin_rd_r;
  logic             bin_rv_r;
  logic [PIX_W-1:0] bin_ra;
  logic [BIN_W-1:0] bin_q;

  assign bin_ra = (state_r == ST_SCAN) ? idx_r : in_pixel;
  assign bin_q  = bin_rv_r ? bin_rd_r : '0;

  // Count pipeline: read at acceptance, increment and write in the next cycle.
  // The last write is forwarded to a count of the same bin that read the
  // memory in the cycle of that write.
  logic             cnt_v_r;
  logic [PIX_W-1:0] cnt_a_r;
  logic             fw_v_r;
  logic [PIX_W-1:0] fw_a_r;
  logic [BIN_W-1:0] fw_d_r;
  logic [BIN_W-1:0] cnt_base, cnt_inc;

  always_comb begin
    if (fw_v_r && (fw_a_r == cnt_a_r)) begin
      cnt_base = fw_d_r;
    end else begin
      cnt_base = bin_q;
    end
    if (cnt_base < BIN_W'(FRAME_PIXELS)) begin
      cnt_inc = cnt_base + BIN_W'(1);
    end else begin
      cnt_inc = cnt_base;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_v_r) begin
      bin_mem[cnt_a_r] <= cnt_inc;
    end
    bin_rd_r <= bin_mem[bin_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LEVELS; i++) begin
        bin_vld_r[i] <= 1'b0;
      end
    end else if (clr_acc) begin
      // A clear follows any count still writing, so it wins.
      for (int i = 0; i < LEVELS; i++) begin
        bin_vld_r[i] <= 1'b0;
      end
    end else if (cnt_v_r) begin
      bin_vld_r[cnt_a_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_rv_r <= 1'b0;
      cnt_v_r  <= 1'b0;
      fw_v_r   <= 1'b0;
    end else begin
      bin_rv_r <= bin_vld_r[bin_ra] && !clr_acc;
      cnt_v_r  <= cnt_acc;
      fw_v_r   <= cnt_v_r && !clr_acc;
    end
  end

  always_ff @(posedge clk) begin
    cnt_a_r <= in_pixel;
    fw_a_r  <= cnt_a_r;
    fw_d_r  <= cnt_inc;
  end

  // Build sequencer: issue one bin read per cycle, then let the pipe drain.
  logic v0_r, v1_r, v2_r, v3_r, v4_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (bld_acc) begin
          state_nxt = ST_SCAN;
          idx_nxt   = '0;
        end
      end
      ST_SCAN: begin
        idx_nxt = idx_r + PIX_W'(1);
        if (idx_r == PIX_W'(LEVELS - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!(v0_r || v1_r || v2_r || v3_r)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Build pipeline.
  //   v0: bin read issued        v1: cumulative sum updated
  //   v2: numerator formed       v3: reciprocal product
  //   v4: quotient estimate and its product with the frame size
  // The correction and the table write happen while v4 is high.
  logic [PIX_W-1:0]  a0_r, a1_r, a2_r, a3_r, a4_r;
  logic [BIN_W-1:0]  cum_r;
  logic [BIN_W:0]    cum_sum;
  logic [BIN_W-1:0]  cum_sat;
  logic [NUM_W-1:0]  num2_r, num3_r, num4_r;
  logic [PROD_W-1:0] prod3_r;
  logic [PIX_W-1:0]  qe_est, qe4_r;
  logic [NUM_W-1:0]  qn4_r;
  logic [NUM_W-1:0]  rem;
  logic [PIX_W-1:0]  q_fix;
  logic [PIX_W-1:0]  tbl_wd;

  assign cum_sum = {1'b0, cum_r} + {1'b0, bin_q};
  assign cum_sat = (cum_sum > (BIN_W + 1)'(FRAME_PIXELS)) ? BIN_W'(FRAME_PIXELS)
                                                          : cum_sum[BIN_W-1:0];
  assign qe_est  = prod3_r[RECIP_SHIFT +: PIX_W];
  assign rem     = num4_r - qn4_r;
  assign q_fix   = qe4_r + PIX_W'(rem >= NUM_W'(FRAME_PIXELS));
  assign tbl_wd  = q_fix >> shift_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r  <= 1'b0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      cum_r <= '0;
    end else begin
      v0_r <= (state_r == ST_SCAN);
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      // cum_r doubles as the running total left by the last build.
      if (clr_acc || bld_acc) begin
        cum_r <= '0;
      end else if (v0_r) begin
        cum_r <= cum_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    a0_r    <= idx_r;
    a1_r    <= a0_r;
    a2_r    <= a1_r;
    a3_r    <= a2_r;
    a4_r    <= a3_r;
    num2_r  <= NUM_W'(({NUM_W'(cum_r), 8'b0} - {8'b0, NUM_W'(cum_r)})
                      + (NUM_W + 8)'(HALF_FRAME));
    num3_r  <= num2_r;
    num4_r  <= num3_r;
    prod3_r <= PROD_W'(num2_r) * PROD_W'(RECIP);
    qe4_r   <= qe_est;
    qn4_r   <= NUM_W'(qe_est) * NUM_W'(FRAME_PIXELS);
  end

  // Mapping table memory: written by the build pipe, read by map items.
  logic [PIX_W-1:0] tbl_mem [LEVELS];
  logic [PIX_W-1:0] tbl_rd_r;

  always_ff @(posedge clk) begin
    if (v4_r) begin
      tbl_mem[a4_r] <= tbl_wd;
    end
    if (map_acc) begin
      tbl_rd_r <= tbl_mem[in_pixel];
    end
  end

  // Output register. The bypass choice and the raw pixel are captured with
  // the table read, so a stalled result keeps its value.
  logic             out_valid_r;
  logic             byp_r;
  logic [PIX_W-1:0] px_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (map_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (map_acc) begin
      byp_r <= !enable_r;
      px_r  <= in_pixel;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_mapped_pixel = byp_r ? px_r : tbl_rd_r;

endmodule
`default_nettype wire

// ----- hdl/heq_checker.sv -----
// Port-level checker for the histogram equalizer core and its bind.
// Depends on heq_pkg and on histogram_equalizer_core.
`default_nettype none
module heq_checker (
  input wire                            clk,
  input wire                            rst_n,
  input wire                            in_valid,
  input wire                            in_ready,
  input wire [heq_pkg::OP_W-1:0]        in_opcode,
  input wire                            out_valid,
  input wire                            out_ready,
  input wire [heq_pkg::PIX_W-1:0]       out_mapped_pixel
);
  import heq_pkg::*;

  logic acc;
  assign acc = in_valid && in_ready;

  // A stalled result stays and keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mapped_pixel))
    else $error("stalled result changed or dropped");

  // A map item shows its result in the next cycle.
  a_map_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_opcode == OP_MAP) |=> out_valid)
    else $error("map item gave no result");

  // Other items never create a result.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_opcode != OP_MAP) && !out_valid |=> !out_valid)
    else $error("result without a map item");

  // A build closes the input while it walks the bins.
  a_build_busy: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_opcode == OP_BUILD) |=> !in_ready)
    else $error("input open right after a build item");

endmodule

bind histogram_equalizer_core heq_checker u_heq_checker (.*);
`default_nettype wire
